[rtl/ascon_pkg.sv]
// Shared types, codes and permutation round function for the ASCON-128 encryptor.
package ascon_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned LenW   = 4;
  localparam int unsigned RndW   = 4;

  localparam logic [WordW-1:0] InitVector = 64'h8040_0c06_0000_0000;
  localparam logic [WordW-1:0] AllOnes    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [WordW-1:0] PadTop     = 64'h8000_0000_0000_0000;
  localparam logic [LenW-1:0]  FullLen    = 4'd8;
  localparam logic [RndW-1:0]  FirstRnd12 = 4'd0;
  localparam logic [RndW-1:0]  FirstRnd6  = 4'd6;
  localparam logic [RndW-1:0]  LastRnd    = 4'd11;

  localparam logic [0:0]       KeyHiIdx   = 1'b0;
  localparam logic [0:0]       KeyLoIdx   = 1'b1;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_AD    = 2'd1,
    OP_PT    = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic {
    KIND_CT  = 1'b0,
    KIND_TAG = 1'b1
  } kind_t;

  typedef logic [4:0][WordW-1:0] perm_state_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [WordW-1:0] word_a;
    logic [WordW-1:0] word_b;
    logic [LenW-1:0]  valid_bytes;
  } in_beat_t;

  typedef struct packed {
    logic [WordW-1:0] out_word;
    logic             out_kind;
    logic [LenW-1:0]  out_bytes;
    logic             last_of_run;
  } out_beat_t;

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] v, input int unsigned n);
    return (v >> n) | (v << (WordW - n));
  endfunction

  function automatic logic [7:0] round_const(input logic [RndW-1:0] r);
    return {4'hF - r, r};
  endfunction

  // Leading n bytes kept, n in 0..8
  function automatic logic [WordW-1:0] byte_mask(input logic [LenW-1:0] n);
    return ~(AllOnes >> {n, 3'b000});
  endfunction

  function automatic logic [WordW-1:0] pad_word(input logic [WordW-1:0] w,
                                                input logic [LenW-1:0] n);
    logic [WordW-1:0] res;
    if (n == FullLen) begin
      res = w;
    end else begin
      res = (w & byte_mask(n)) ^ (PadTop >> {n, 3'b000});
    end
    return res;
  endfunction

  function automatic perm_state_t ascon_round(input perm_state_t s, input logic [7:0] c);
    perm_state_t a;
    perm_state_t t;
    perm_state_t o;
    a = s;
    a[2] = a[2] ^ {56'd0, c};
    a[0] = a[0] ^ a[4];
    a[4] = a[4] ^ a[3];
    a[2] = a[2] ^ a[1];
    t[0] = a[0] ^ (~a[1] & a[2]);
    t[1] = a[1] ^ (~a[2] & a[3]);
    t[2] = a[2] ^ (~a[3] & a[4]);
    t[3] = a[3] ^ (~a[4] & a[0]);
    t[4] = a[4] ^ (~a[0] & a[1]);
    t[1] = t[1] ^ t[0];
    t[0] = t[0] ^ t[4];
    t[3] = t[3] ^ t[2];
    t[2] = ~t[2];
    o[0] = t[0] ^ rotr(t[0], 19) ^ rotr(t[0], 28);
    o[1] = t[1] ^ rotr(t[1], 61) ^ rotr(t[1], 39);
    o[2] = t[2] ^ rotr(t[2], 1)  ^ rotr(t[2], 6);
    o[3] = t[3] ^ rotr(t[3], 10) ^ rotr(t[3], 17);
    o[4] = t[4] ^ rotr(t[4], 7)  ^ rotr(t[4], 41);
    return o;
  endfunction

endpackage

[rtl/ascon_if.sv]
// Valid/ready channel interfaces for input and result beats.
interface ascon_in_if import ascon_pkg::*;;
  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ascon_out_if import ascon_pkg::*;;
  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/ascon128_aead_encrypt.sv]
// ASCON-128 AEAD encryptor: sequencer around one shared permutation round.
//
//  channel   dir  handshake            beat
//  cfg_*     in   cfg_we               key word, cfg_index 0 high, 1 low
//  in_ch     in   valid/ready          op, word_a, word_b, valid_bytes
//  out_ch    out  valid/ready          out_word, out_kind, out_bytes, last_of_run
//
//  One permutation round per cycle in a single round unit; the round count sets latency.
//  Start and the final block run the long round sequence, other AD and plaintext blocks the
//  short one; the final block then emits two tag words, each waiting on any output stall.
//  rst_n is synchronous; it clears the sequencer, phase, keys and the output valid flag.
//  in_ch.ready drops while rounds run, a tag is pending or a held result is not taken; out_ch stalls hold the result.
module ascon128_aead_encrypt import ascon_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [WordW-1:0]  cfg_data,
  ascon_in_if.sink          in_ch,
  ascon_out_if.source       out_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PERM,
    S_TAG0,
    S_TAG1
  } seq_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_AD   = 2'd1,
    PH_SEP  = 2'd2,
    PH_PT   = 2'd3
  } phase_t;

  seq_t             state_r,     state_nxt;
  phase_t           phase_r,     phase_nxt;
  logic [RndW-1:0]  rnd_r,       rnd_nxt;
  logic             keyx_r,      keyx_nxt;
  logic             fin_r,       fin_nxt;
  perm_state_t      x_r,         x_nxt;
  logic [WordW-1:0] key_hi_r,    key_hi_nxt;
  logic [WordW-1:0] key_lo_r,    key_lo_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_beat_t        out_data_r,  out_data_nxt;

  logic             slot_free;
  logic             in_fire;
  logic [LenW-1:0]  n_len;
  logic [WordW-1:0] absorbed;
  logic [WordW-1:0] ct_word;
  perm_state_t      rnd_out;

  assign slot_free   = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && slot_free;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign n_len       = in_ch.data.valid_bytes[3] ? FullLen : in_ch.data.valid_bytes;
  assign absorbed    = pad_word(in_ch.data.word_a, n_len);
  assign ct_word     = x_r[0] ^ absorbed;
  assign rnd_out     = ascon_round(x_r, round_const(rnd_r));

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    rnd_nxt       = rnd_r;
    keyx_nxt      = keyx_r;
    fin_nxt       = fin_r;
    x_nxt         = x_r;
    key_hi_nxt    = key_hi_r;
    key_lo_nxt    = key_lo_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_we) begin
      if (cfg_index == KeyHiIdx) begin
        key_hi_nxt = cfg_data;
      end else begin
        key_lo_nxt = cfg_data;
      end
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (op_t'(in_ch.data.op))
            OP_START: begin
              x_nxt[0]  = InitVector;
              x_nxt[1]  = key_hi_r;
              x_nxt[2]  = key_lo_r;
              x_nxt[3]  = in_ch.data.word_a;
              x_nxt[4]  = in_ch.data.word_b;
              rnd_nxt   = FirstRnd12;
              keyx_nxt  = 1'b1;
              fin_nxt   = 1'b0;
              phase_nxt = PH_AD;
              state_nxt = S_PERM;
            end
            OP_AD: begin
              if (phase_r == PH_AD) begin
                x_nxt[0]  = ct_word;
                rnd_nxt   = FirstRnd6;
                keyx_nxt  = 1'b0;
                fin_nxt   = 1'b0;
                state_nxt = S_PERM;
                if (n_len != FullLen) begin
                  phase_nxt = PH_SEP;
                end
              end
            end
            OP_PT: begin
              if (phase_r != PH_IDLE) begin
                if (phase_r != PH_PT) begin
                  x_nxt[4] = x_r[4] ^ 64'd1;
                end
                x_nxt[0]      = ct_word;
                out_valid_nxt = 1'b1;
                out_data_nxt.out_kind = KIND_CT;
                state_nxt     = S_PERM;
                if (n_len == FullLen) begin
                  out_data_nxt.out_word    = ct_word;
                  out_data_nxt.out_bytes   = FullLen;
                  out_data_nxt.last_of_run = 1'b1;
                  rnd_nxt   = FirstRnd6;
                  keyx_nxt  = 1'b0;
                  fin_nxt   = 1'b0;
                  phase_nxt = PH_PT;
                end else begin
                  out_data_nxt.out_word    = ct_word & byte_mask(n_len);
                  out_data_nxt.out_bytes   = n_len;
                  out_data_nxt.last_of_run = 1'b0;
                  x_nxt[1]  = x_r[1] ^ key_hi_r;
                  x_nxt[2]  = x_r[2] ^ key_lo_r;
                  rnd_nxt   = FirstRnd12;
                  keyx_nxt  = 1'b1;
                  fin_nxt   = 1'b1;
                  phase_nxt = PH_IDLE;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_PERM: begin
        x_nxt = rnd_out;
        if (rnd_r == LastRnd) begin
          if (keyx_r) begin
            x_nxt[3] = rnd_out[3] ^ key_hi_r;
            x_nxt[4] = rnd_out[4] ^ key_lo_r;
          end
          state_nxt = fin_r ? S_TAG0 : S_IDLE;
        end else begin
          rnd_nxt = rnd_r + 4'd1;
        end
      end
      S_TAG0: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{out_word: x_r[3], out_kind: KIND_TAG,
                            out_bytes: FullLen, last_of_run: 1'b0};
          state_nxt     = S_TAG1;
        end
      end
      S_TAG1: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{out_word: x_r[4], out_kind: KIND_TAG,
                            out_bytes: FullLen, last_of_run: 1'b1};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      rnd_r       <= FirstRnd12;
      keyx_r      <= 1'b0;
      fin_r       <= 1'b0;
      key_hi_r    <= '0;
      key_lo_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      rnd_r       <= rnd_nxt;
      keyx_r      <= keyx_nxt;
      fin_r       <= fin_nxt;
      key_hi_r    <= key_hi_nxt;
      key_lo_r    <= key_lo_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r        <= x_nxt;
    out_data_r <= out_data_nxt;
  end

  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PERM |-> rnd_r <= LastRnd)
    else $error("round counter past last round");

  a_tag_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.out_kind == KIND_TAG |-> out_data_r.out_bytes == FullLen)
    else $error("tag beat with short length");

  a_tag_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TAG1 && slot_free |=> phase_r == PH_IDLE && state_r == S_IDLE)
    else $error("message not closed after second tag");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> state_r == S_IDLE && slot_free)
    else $error("input taken while busy");

  a_fin_keyx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PERM && fin_r |-> keyx_r && phase_r == PH_IDLE)
    else $error("finalization without key mix");

endmodule
